>>> hw/rtl/cz_pkg.sv
// cz_pkg: shared constants and result type of the collocation z-score block
// used by cz_front, cz_queue, cz_back and collocation_zscore; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cz_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int Z_BITS         = 33;
    localparam int REG_BITS       = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int ADDR_BITS      = 1;

    localparam logic [ADDR_BITS-1:0] ADDR_CORPUS_WORDS = '0;

    typedef struct packed {
        logic signed [Z_BITS-1:0] z;
        logic                     undef;
        logic                     sat;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/cz_front.sv
// cz_front: takes a word, forms the two count products and classifies the item
// depends on cz_pkg
`timescale 1ns / 1ps
`default_nettype none

module cz_front #(
    parameter int COUNT_BITS = cz_pkg::COUNT_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_accept,
    input  wire logic [COUNT_BITS-1:0]   i_pair,
    input  wire logic [COUNT_BITS-1:0]   i_w1,
    input  wire logic [COUNT_BITS-1:0]   i_w2,
    input  wire logic [COUNT_BITS-1:0]   i_n,
    output logic                         o_push,
    output logic [4*COUNT_BITS+1:0]      o_data
);
    import cz_pkg::*;

    localparam int PB = 2 * COUNT_BITS;

    logic          r_vld;
    logic [PB-1:0] r_prod;
    logic [PB-1:0] r_pn;
    logic          neg;
    logic [PB-1:0] num;
    logic          undef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
        if (i_accept) begin
            r_prod <= PB'(i_w1) * PB'(i_w2);
            r_pn   <= PB'(i_pair) * PB'(i_n);
        end
    end

    always_comb begin
        neg    = r_prod > r_pn;
        num    = neg ? (r_prod - r_pn) : (r_pn - r_prod);
        undef  = (i_n == '0) || (r_prod == '0);
        o_push = r_vld;
        o_data = {undef, neg, r_prod, num};
    end

endmodule

`default_nettype wire

>>> hw/rtl/cz_queue.sv
// cz_queue: small word queue between front and back
// depends on cz_pkg
`timescale 1ns / 1ps
`default_nettype none

module cz_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cz_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_level
);
    import cz_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [LW-1:0]    r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule

`default_nettype wire

>>> hw/rtl/cz_back.sv
// cz_back: sequencer that forms w1*w2*n and num^2, divides, takes the root
// depends on cz_pkg
`timescale 1ns / 1ps
`default_nettype none

module cz_back #(
    parameter int COUNT_BITS = cz_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = cz_pkg::FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_empty,
    input  wire logic [4*COUNT_BITS+1:0] i_data,
    input  wire logic [COUNT_BITS-1:0]   i_n,
    output logic                         o_pop,
    output logic                         o_valid,
    output cz_pkg::t_res                 o_res
);
    import cz_pkg::*;

    localparam int C   = COUNT_BITS;
    localparam int MBW = 2 * C;
    localparam int PW  = 4 * C;
    localparam int MW  = 3 * C;
    localparam int DW  = 4 * C + 2 * FRAC_BITS;
    localparam int QB  = 2 * Z_BITS;
    localparam int SW  = Z_BITS + 3;
    localparam int CW  = $clog2(DW + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MULM = 6'b000010,
        S_MULN = 6'b000100,
        S_DIV  = 6'b001000,
        S_SQRT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_cnt;
    logic [PW-1:0]        r_ma;
    logic [MBW-1:0]       r_mb;
    logic [PW-1:0]        r_acc;
    logic [MBW-1:0]       r_num;
    logic                 r_neg;
    logic [MW-1:0]        r_m;
    logic [DW-1:0]        r_div;
    logic [MW-1:0]        r_rem;
    logic [QB-1:0]        r_q;
    logic                 r_ovf;
    logic [QB-1:0]        r_x;
    logic [Z_BITS-1:0]    r_root;
    logic [SW-1:0]        r_srem;
    logic                 r_valid;
    t_res                 r_res;

    logic [MBW-1:0]       in_num;
    logic [MBW-1:0]       in_prod;
    logic                 in_neg;
    logic                 in_undef;
    logic [PW-1:0]        n_acc;
    logic [MW:0]          n_t;
    logic                 ge;
    logic [MW:0]          n_rem;
    logic [SW-1:0]        n_st;
    logic [SW-1:0]        n_tr;
    logic                 sge;
    logic                 last;
    logic                 sat;
    logic signed [Z_BITS-1:0] z;

    always_comb begin
        in_num   = i_data[MBW-1:0];
        in_prod  = i_data[2*MBW-1:MBW];
        in_neg   = i_data[2*MBW];
        in_undef = i_data[2*MBW+1];
        o_pop    = (r_state == S_IDLE) && !i_empty;
        n_acc    = r_acc + (r_mb[0] ? r_ma : '0);
        n_t      = {r_rem, r_div[DW-1]};
        ge       = n_t >= {1'b0, r_m};
        n_rem    = ge ? (n_t - {1'b0, r_m}) : n_t;
        n_st     = {r_srem[SW-3:0], r_x[QB-1:QB-2]};
        n_tr     = SW'({r_root, 2'b01});
        sge      = n_st >= n_tr;
        last     = (r_cnt == CW'(1));
        if (r_neg) begin
            sat = r_root[Z_BITS-1] && (r_root[Z_BITS-2:0] != '0);
        end else begin
            sat = r_root[Z_BITS-1];
        end
        if (sat) begin
            z = r_neg ? {1'b1, {(Z_BITS-1){1'b0}}} : {1'b0, {(Z_BITS-1){1'b1}}};
        end else begin
            z = r_neg ? -$signed(r_root) : $signed(r_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (in_undef) begin
                            r_res   <= '{z: '0, undef: 1'b1, sat: 1'b0};
                            r_valid <= 1'b1;
                        end else begin
                            r_ma    <= PW'(in_prod);
                            r_mb    <= MBW'(i_n);
                            r_acc   <= '0;
                            r_num   <= in_num;
                            r_neg   <= in_neg;
                            r_cnt   <= CW'(MBW);
                            r_state <= S_MULM;
                        end
                    end
                end
                S_MULM: begin
                    r_acc <= n_acc;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (last) begin
                        r_m     <= n_acc[MW-1:0];
                        r_ma    <= PW'(r_num);
                        r_mb    <= r_num;
                        r_acc   <= '0;
                        r_cnt   <= CW'(MBW);
                        r_state <= S_MULN;
                    end
                end
                S_MULN: begin
                    r_acc <= n_acc;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (last) begin
                        r_div   <= {n_acc, {(2*FRAC_BITS){1'b0}}};
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= CW'(DW);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem[MW-1:0];
                    r_div <= r_div << 1;
                    r_q   <= {r_q[QB-2:0], ge};
                    r_ovf <= r_ovf | r_q[QB-1];
                    r_cnt <= r_cnt - 1'b1;
                    if (last) begin
                        r_x     <= (r_ovf || r_q[QB-1]) ? '1 : {r_q[QB-2:0], ge};
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_cnt   <= CW'(Z_BITS);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srem <= sge ? (n_st - n_tr) : n_st;
                    r_root <= {r_root[Z_BITS-2:0], sge};
                    r_x    <= r_x << 2;
                    r_cnt  <= r_cnt - 1'b1;
                    if (last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_res   <= '{z: z, undef: 1'b0, sat: sat};
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTH
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.undef |-> (r_res.z == '0) && !r_res.sat)
        else $error("undefined result with nonzero score or saturation");

    a_out_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_valid)
        else $error("finished item not presented");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.sat |->
            (r_res.z == {1'b1, {(Z_BITS-1){1'b0}}}) ||
            (r_res.z == {1'b0, {(Z_BITS-1){1'b1}}}))
        else $error("saturated score not at a range end");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/collocation_zscore.sv
// collocation_zscore: top level, config register, front, queue and back
// depends on cz_pkg, cz_front, cz_queue, cz_back
//
// usage: set corpus_words through the register port (address 0) while idle,
// then raise start with the three counts; a word is taken when start is high
// and busy is low. busy rises when the queue between front and back, counting
// an item being pushed into it, is full. the front registers both count
// products when it takes a word and queues the item in the cycle after, so
// words can be taken on consecutive cycles while busy is low. the back runs
// one item at a time: 2*COUNT_BITS shift-add steps for w1*w2*n, 2*COUNT_BITS
// for num squared, 4*COUNT_BITS+2*FRAC_BITS restoring divide steps and 33
// root steps, with an idle state before and an output state after them. an
// item with an undefined score skips the steps and is output from idle.
// each result is shown for one cycle with o_valid; the receiver cannot stall.
// reset empties the queue, returns the back to idle and sets corpus_words to 1.
`timescale 1ns / 1ps
`default_nettype none

module collocation_zscore #(
    parameter int COUNT_BITS = cz_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = cz_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cz_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [cz_pkg::REG_BITS-1:0]       pwdata,
    output logic [cz_pkg::REG_BITS-1:0]            prdata,
    output logic                                   pready,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [31:0]                       i_pair_count,
    input  wire logic [31:0]                       i_first_word_count,
    input  wire logic [31:0]                       i_second_word_count,
    output logic                                   o_valid,
    output logic signed [cz_pkg::Z_BITS-1:0]       o_z_score,
    output logic                                   o_undefined,
    output logic                                   o_saturated
);
    import cz_pkg::*;

    localparam int EW = 4 * COUNT_BITS + 2;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [REG_BITS-1:0]   r_corpus;
    logic                  accept;
    logic                  push;
    logic [EW-1:0]         f_data;
    logic [EW-1:0]         q_data;
    logic                  q_empty;
    logic [LW-1:0]         q_level;
    logic                  pop;
    t_res                  res;
    logic [COUNT_BITS-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corpus <= REG_BITS'(1);
        end else if (psel && penable && pwrite && (paddr == ADDR_CORPUS_WORDS)) begin
            r_corpus <= pwdata;
        end
    end

    assign prdata = (paddr == ADDR_CORPUS_WORDS) ? r_corpus : '0;
    assign pready = 1'b1;
    assign n_cnt  = COUNT_BITS'(r_corpus);
    assign busy   = ((LW+1)'(q_level) + (LW+1)'(push)) >= (LW+1)'(QUEUE_DEPTH);
    assign accept = start && !busy;

    cz_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_pair  (COUNT_BITS'(i_pair_count)),
        .i_w1    (COUNT_BITS'(i_first_word_count)),
        .i_w2    (COUNT_BITS'(i_second_word_count)),
        .i_n     (n_cnt),
        .o_push  (push),
        .o_data  (f_data)
    );

    cz_queue #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (f_data),
        .i_pop  (pop),
        .o_data (q_data),
        .o_empty(q_empty),
        .o_level(q_level)
    );

    cz_back #(
        .COUNT_BITS(COUNT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(q_empty),
        .i_data (q_data),
        .i_n    (n_cnt),
        .o_pop  (pop),
        .o_valid(o_valid),
        .o_res  (res)
    );

    assign o_z_score   = res.z;
    assign o_undefined = res.undef;
    assign o_saturated = res.sat;

endmodule

`default_nettype wire
